>>> src/ipd_pkg.sv
// ----------------------------------------------------------------------------
// IQ packet deframer package
// Shared types and constants for the deframer core, top level and testbench.
// ----------------------------------------------------------------------------
package ipd_pkg;

  // Header marker bytes, 'D' then 'R'.
  localparam logic [7:0]  MARK_FIRST  = 8'h44;
  localparam logic [7:0]  MARK_SECOND = 8'h52;

  // Header positions: seven header bytes, position seven means payload.
  localparam logic [2:0]  HDR_MARK_FIRST  = 3'd0;
  localparam logic [2:0]  HDR_MARK_SECOND = 3'd1;
  localparam logic [2:0]  HDR_SEQ_LOW     = 3'd2;
  localparam logic [2:0]  HDR_SEQ_HIGH    = 3'd3;
  localparam logic [2:0]  HDR_GAIN        = 3'd4;
  localparam logic [2:0]  HDR_COUNT_LOW   = 3'd5;
  localparam logic [2:0]  HDR_COUNT_HIGH  = 3'd6;
  localparam logic [2:0]  HDR_PAYLOAD     = 3'd7;

  // Index of the last byte of a six-byte sample.
  localparam logic [2:0]  SAMPLE_LAST = 3'd5;

  // Offset binary to two's complement: invert the top bit.
  localparam logic [23:0] OFFSET_BIT = 24'h800000;

  typedef enum logic [1:0] {
    KIND_SAMPLE     = 2'd0,
    KIND_BAD_FORMAT = 2'd1,
    KIND_DROPPED    = 2'd2,
    KIND_SEQ_GAP    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    kind_e              kind;
    logic signed [23:0] i_value;
    logic signed [23:0] q_value;
    logic [7:0]         gain;
    logic [15:0]        seq_number;
  } result_t;

endpackage

>>> src/ipd_stream_if.sv
// ----------------------------------------------------------------------------
// IQ packet deframer channels
// Valid/ready interfaces for the byte input and the result output.
// ----------------------------------------------------------------------------
interface ipd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface ipd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [23:0] i_value;
  logic signed [23:0] q_value;
  logic [7:0]         gain;
  logic [15:0]        seq_number;

  modport source (output valid, output kind, output i_value, output q_value,
                  output gain, output seq_number, input ready);
  modport sink   (input valid, input kind, input i_value, input q_value,
                  input gain, input seq_number, output ready);
endinterface

>>> src/ipd_frame_core.sv
// ----------------------------------------------------------------------------
// IQ packet deframer core
// Header parser, sequence tracker and sample assembler, one byte per step.
// ----------------------------------------------------------------------------
module ipd_frame_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  ipd_pkg::in_item_t item_i,
  output ipd_pkg::result_t  result_o
);

  logic [2:0]  hdr_pos_q, hdr_pos_d;
  logic [2:0]  smp_pos_q, smp_pos_d;
  logic [15:0] left_q, left_d;
  logic [15:0] exp_seq_q, exp_seq_d;
  logic        exp_known_q, exp_known_d;
  logic [15:0] pkt_seq_q, pkt_seq_d;
  logic [7:0]  pkt_gain_q, pkt_gain_d;
  logic [39:0] smp_bytes_q, smp_bytes_d;
  logic        discard_q, discard_d;

  logic        bad;
  logic        drop;
  logic [16:0] next_seq;
  logic [47:0] full;

  always_comb begin
    hdr_pos_d   = hdr_pos_q;
    smp_pos_d   = smp_pos_q;
    left_d      = left_q;
    exp_seq_d   = exp_seq_q;
    exp_known_d = exp_known_q;
    pkt_seq_d   = pkt_seq_q;
    pkt_gain_d  = pkt_gain_q;
    smp_bytes_d = smp_bytes_q;
    discard_d   = discard_q;
    result_o    = '0;
    bad         = 1'b0;
    drop        = 1'b0;
    next_seq    = {1'b0, pkt_seq_q} + 17'd2;
    full        = {smp_bytes_q, item_i.data_byte};

    if (step_i) begin
      if (discard_q) begin
        // Rest of this packet is ignored.
      end else if (hdr_pos_q != ipd_pkg::HDR_PAYLOAD) begin
        case (hdr_pos_q)
          ipd_pkg::HDR_MARK_FIRST:  bad = (item_i.data_byte != ipd_pkg::MARK_FIRST);
          ipd_pkg::HDR_MARK_SECOND: bad = (item_i.data_byte != ipd_pkg::MARK_SECOND);
          ipd_pkg::HDR_SEQ_LOW:     pkt_seq_d = {8'h00, item_i.data_byte};
          ipd_pkg::HDR_SEQ_HIGH:    pkt_seq_d = {item_i.data_byte, pkt_seq_q[7:0]};
          ipd_pkg::HDR_GAIN:        pkt_gain_d = item_i.data_byte;
          ipd_pkg::HDR_COUNT_LOW:   left_d = {8'h00, item_i.data_byte};
          default:                  left_d = {item_i.data_byte, left_q[7:0]};
        endcase
        if (bad) begin
          result_o.hit  = 1'b1;
          result_o.kind = ipd_pkg::KIND_BAD_FORMAT;
          discard_d     = 1'b1;
        end else if (hdr_pos_q == ipd_pkg::HDR_COUNT_HIGH) begin
          hdr_pos_d = ipd_pkg::HDR_PAYLOAD;
          if (exp_known_q && (pkt_seq_q != exp_seq_q)) begin
            result_o.hit        = 1'b1;
            result_o.gain       = pkt_gain_q;
            result_o.seq_number = pkt_seq_q;
            if ((pkt_seq_q < exp_seq_q) && (pkt_seq_q[0] == exp_seq_q[0])) begin
              drop          = 1'b1;
              result_o.kind = ipd_pkg::KIND_DROPPED;
              discard_d     = 1'b1;
            end else begin
              result_o.kind = ipd_pkg::KIND_SEQ_GAP;
            end
          end
          if (!drop) begin
            // Past the top the expectation wraps to 1 or 0 by parity.
            if (next_seq[16]) begin
              exp_seq_d = {15'd0, ~next_seq[0]};
            end else begin
              exp_seq_d = next_seq[15:0];
            end
            exp_known_d = 1'b1;
          end
        end else begin
          hdr_pos_d = hdr_pos_q + 3'd1;
        end
      end else if (left_q != 16'd0) begin
        if (smp_pos_q != ipd_pkg::SAMPLE_LAST) begin
          smp_bytes_d = {smp_bytes_q[31:0], item_i.data_byte};
          smp_pos_d   = smp_pos_q + 3'd1;
        end else begin
          result_o.hit        = 1'b1;
          result_o.kind       = ipd_pkg::KIND_SAMPLE;
          result_o.i_value    = full[47:24] ^ ipd_pkg::OFFSET_BIT;
          result_o.q_value    = full[23:0] ^ ipd_pkg::OFFSET_BIT;
          result_o.gain       = pkt_gain_q;
          result_o.seq_number = pkt_seq_q;
          left_d              = left_q - 16'd1;
          smp_pos_d           = '0;
          smp_bytes_d         = '0;
        end
      end

      if (item_i.end_of_packet) begin
        // A packet that ends inside its header is malformed.
        if (!result_o.hit && !discard_d && (hdr_pos_d != ipd_pkg::HDR_PAYLOAD)) begin
          result_o      = '0;
          result_o.hit  = 1'b1;
          result_o.kind = ipd_pkg::KIND_BAD_FORMAT;
        end
        hdr_pos_d   = '0;
        smp_pos_d   = '0;
        left_d      = '0;
        smp_bytes_d = '0;
        discard_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q   <= '0;
      smp_pos_q   <= '0;
      left_q      <= '0;
      exp_seq_q   <= '0;
      exp_known_q <= 1'b0;
      pkt_seq_q   <= '0;
      pkt_gain_q  <= '0;
      smp_bytes_q <= '0;
      discard_q   <= 1'b0;
    end else begin
      hdr_pos_q   <= hdr_pos_d;
      smp_pos_q   <= smp_pos_d;
      left_q      <= left_d;
      exp_seq_q   <= exp_seq_d;
      exp_known_q <= exp_known_d;
      pkt_seq_q   <= pkt_seq_d;
      pkt_gain_q  <= pkt_gain_d;
      smp_bytes_q <= smp_bytes_d;
      discard_q   <= discard_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hdr_pos_q != ipd_pkg::HDR_PAYLOAD |-> smp_pos_q == 3'd0)
    else $error("sample bytes collected while the header is open");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_pos_q <= ipd_pkg::SAMPLE_LAST)
    else $error("sample byte position out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.end_of_packet |=> hdr_pos_q == 3'd0 && !discard_q)
    else $error("packet state not cleared at end of packet");
`endif

endmodule

>>> src/iq_packet_deframer.sv
// ----------------------------------------------------------------------------
// IQ packet deframer
// Byte-serial deframer that turns I/Q packets into Q1.23 sample items.
// ----------------------------------------------------------------------------
// Usage:
// Bytes of a packet enter on in_i, one item per byte, with end_of_packet set
// on the final byte. Results leave on out_o: one item per complete six-byte
// sample (kind 0), or a status item for a bad header marker or short packet
// (kind 1), a dropped stale packet (kind 2), or an accepted sequence gap
// (kind 3). Bytes that produce nothing leave no item.
// The block is a two-register pipeline: a byte is captured in the input
// register, processed combinationally by the deframer core, and any result is
// captured in the output register. One byte is taken every cycle while out_o
// is ready; the rate is set by the core, which updates its state once per
// byte.
// When the receiver stalls with a result waiting, the input register still
// fills once, then in_i.ready drops until the output register empties.
// Reset clears all packet state and the expected sequence number, so the
// first packet after reset is accepted with any number.
// ----------------------------------------------------------------------------
module iq_packet_deframer (
  input  logic   clk_i,
  input  logic   rst_ni,
  ipd_in_if.sink   in_i,
  ipd_out_if.source out_o
);

  ipd_pkg::in_item_t in_q;
  logic              in_valid_q;
  ipd_pkg::result_t  res;
  ipd_pkg::result_t  out_q;
  logic              out_valid_q;
  logic              advance;

  // The held byte moves on whenever the output register can take a result.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.data_byte     <= in_i.data_byte;
      in_q.end_of_packet <= in_i.end_of_packet;
    end
  end

  ipd_frame_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.hit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.hit) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.i_value    = out_q.i_value;
  assign out_o.q_value    = out_q.q_value;
  assign out_o.gain       = out_q.gain;
  assign out_o.seq_number = out_q.seq_number;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled while the output could move");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("held byte lost or changed during a stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind != ipd_pkg::KIND_SAMPLE |->
      out_q.i_value == 24'sd0 && out_q.q_value == 24'sd0)
    else $error("status item carries sample data");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == ipd_pkg::KIND_BAD_FORMAT |->
      out_q.gain == 8'd0 && out_q.seq_number == 16'd0)
    else $error("bad format item carries header fields");
`endif

endmodule

>>> bench/iq_packet_deframer_tb.sv
// ----------------------------------------------------------------------------
// IQ packet deframer testbench
// Feeds packets byte by byte through the valid/ready input channel and checks
// every result item against a cycle-free model of the deframer kept in the
// bench. Directed packets cover the header corner cases. Random packets then
// follow: mostly well-formed with random content, some truncated and some
// noise. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module iq_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 12;
  localparam int RANDOM_BYTES  = 830;
  localparam int LONG_HOLD     = 250;
  localparam int HOLD_AFTER    = 300;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 8;

  // One byte waiting to be offered. When drain_first is set, the sender waits
  // until every result already due has come out before it offers this byte.
  typedef struct {
    ipd_pkg::in_item_t item;
    bit                drain_first;
  } pending_byte_t;

  // One result item as the deframer should produce it.
  typedef struct {
    ipd_pkg::kind_e kind;
    logic [23:0]    i_value;
    logic [23:0]    q_value;
    logic [7:0]     gain;
    logic [15:0]    seq_number;
  } frame_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ipd_in_if  in_if ();
  ipd_out_if out_if ();

  iq_packet_deframer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always #HALF_PERIOD clk = ~clk;

  // Stimulus and scoreboard storage.
  pending_byte_t byte_queue[$];
  logic [7:0]    packet_bytes[$];
  frame_result_t awaited_results[$];

  // Bench copy of the deframer state, advanced once per accepted byte.
  logic [2:0]  hdr_pos;
  logic [2:0]  smp_pos;
  logic [15:0] samples_left;
  logic [15:0] seq_next;
  bit          seq_known;
  logic [15:0] pkt_seq;
  logic [7:0]  pkt_gain;
  logic [39:0] smp_bytes;
  bit          skip_rest;

  // Handshake bookkeeping shared between the clocked processes.
  bit byte_taken;
  int bytes_accepted;
  int idle_cycles;
  int mismatch_count;

  // Sender and receiver pacing.
  int          burst_left;
  int          gap_left;
  int          hold_left;
  bit          long_hold_done;
  logic [15:0] stall_phase;
  int          stall_mode;

  initial begin
    hdr_pos        = ipd_pkg::HDR_MARK_FIRST;
    smp_pos        = '0;
    samples_left   = '0;
    seq_next       = '0;
    seq_known      = 1'b0;
    pkt_seq        = '0;
    pkt_gain       = '0;
    smp_bytes      = '0;
    skip_rest      = 1'b0;
    byte_taken     = 1'b0;
    bytes_accepted = 0;
    idle_cycles    = 0;
    mismatch_count = 0;
    burst_left     = 0;
    gap_left       = 0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    stall_phase    = '0;
    stall_mode     = 0;
  end

  // --------------------------------------------------------------------------
  // Deframer prediction
  // --------------------------------------------------------------------------

  task automatic queue_result(input ipd_pkg::kind_e kind, input logic [23:0] iv,
                              input logic [23:0] qv, input logic [7:0] gain,
                              input logic [15:0] seq);
    frame_result_t r;
    r.kind       = kind;
    r.i_value    = iv;
    r.q_value    = qv;
    r.gain       = gain;
    r.seq_number = seq;
    awaited_results.push_back(r);
  endtask

  // Advance the bench state by one accepted byte and queue any result it
  // causes. At most one result comes from a single byte.
  task automatic deframe_byte(input logic [7:0] b, input logic eop);
    bit          produced;
    bit          bad;
    bit          stale;
    logic [16:0] next_seq;
    logic [47:0] full;
    produced = 1'b0;
    bad      = 1'b0;
    stale    = 1'b0;
    if (skip_rest) begin
      // Rest of a rejected packet: nothing to do until its last byte.
    end else if (hdr_pos != ipd_pkg::HDR_PAYLOAD) begin
      case (hdr_pos)
        ipd_pkg::HDR_MARK_FIRST:  bad = (b != ipd_pkg::MARK_FIRST);
        ipd_pkg::HDR_MARK_SECOND: bad = (b != ipd_pkg::MARK_SECOND);
        ipd_pkg::HDR_SEQ_LOW:     pkt_seq = {8'h00, b};
        ipd_pkg::HDR_SEQ_HIGH:    pkt_seq[15:8] = b;
        ipd_pkg::HDR_GAIN:        pkt_gain = b;
        ipd_pkg::HDR_COUNT_LOW:   samples_left = {8'h00, b};
        default:                  samples_left[15:8] = b;
      endcase
      if (bad) begin
        queue_result(ipd_pkg::KIND_BAD_FORMAT, '0, '0, '0, '0);
        produced  = 1'b1;
        skip_rest = 1'b1;
      end else if (hdr_pos == ipd_pkg::HDR_COUNT_HIGH) begin
        hdr_pos = ipd_pkg::HDR_PAYLOAD;
        // A number behind the expected one on the same parity is a stale
        // packet and is dropped; any other mismatch is flagged but kept.
        if (seq_known && pkt_seq != seq_next) begin
          stale = (pkt_seq < seq_next) && (pkt_seq[0] == seq_next[0]);
          queue_result(stale ? ipd_pkg::KIND_DROPPED : ipd_pkg::KIND_SEQ_GAP,
                       '0, '0, pkt_gain, pkt_seq);
          produced = 1'b1;
          if (stale) skip_rest = 1'b1;
        end
        // The expectation steps by two; past the top it restarts at 1 for an
        // even sum and at 0 for an odd one.
        if (!stale) begin
          next_seq  = {1'b0, pkt_seq} + 17'd2;
          seq_next  = next_seq[16] ? {15'd0, ~next_seq[0]} : next_seq[15:0];
          seq_known = 1'b1;
        end
      end else begin
        hdr_pos = hdr_pos + 3'd1;
      end
    end else if (samples_left != 0) begin
      if (smp_pos != ipd_pkg::SAMPLE_LAST) begin
        smp_bytes = {smp_bytes[31:0], b};
        smp_pos   = smp_pos + 3'd1;
      end else begin
        full = {smp_bytes, b};
        queue_result(ipd_pkg::KIND_SAMPLE, full[47:24] ^ ipd_pkg::OFFSET_BIT,
                     full[23:0] ^ ipd_pkg::OFFSET_BIT, pkt_gain, pkt_seq);
        produced     = 1'b1;
        samples_left = samples_left - 16'd1;
        smp_pos      = '0;
        smp_bytes    = '0;
      end
    end
    // The last byte closes the packet. A header cut short that has not yet
    // been reported is a format error.
    if (eop) begin
      if (!produced && !skip_rest && hdr_pos != ipd_pkg::HDR_PAYLOAD) begin
        queue_result(ipd_pkg::KIND_BAD_FORMAT, '0, '0, '0, '0);
      end
      hdr_pos      = ipd_pkg::HDR_MARK_FIRST;
      smp_pos      = '0;
      samples_left = '0;
      smp_bytes    = '0;
      skip_rest    = 1'b0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Packet building
  // --------------------------------------------------------------------------

  task automatic append_header(input logic [15:0] seq, input logic [7:0] gain,
                               input logic [15:0] count);
    packet_bytes.push_back(ipd_pkg::MARK_FIRST);
    packet_bytes.push_back(ipd_pkg::MARK_SECOND);
    packet_bytes.push_back(seq[7:0]);
    packet_bytes.push_back(seq[15:8]);
    packet_bytes.push_back(gain);
    packet_bytes.push_back(count[7:0]);
    packet_bytes.push_back(count[15:8]);
  endtask

  // Move the packet under construction to the send queue, flagging its last
  // byte as the end of the packet.
  task automatic flush_packet(input bit drain);
    pending_byte_t pb;
    foreach (packet_bytes[k]) begin
      pb.item.data_byte     = packet_bytes[k];
      pb.item.end_of_packet = (k == packet_bytes.size() - 1);
      pb.drain_first        = drain && (k == 0);
      byte_queue.push_back(pb);
    end
    packet_bytes.delete();
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: bursts of random length separated by random gaps. A byte
  // marked for draining is held back until no result is outstanding.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : byte_driver
    logic          offer;
    pending_byte_t pb;
    offer = in_if.valid;
    if (offer && byte_taken) offer = 1'b0;
    if (!offer && rst_n) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (byte_queue.size() != 0 &&
                   !(byte_queue[0].drain_first && awaited_results.size() != 0)) begin
        pb = byte_queue.pop_front();
        in_if.data_byte     <= pb.item.data_byte;
        in_if.end_of_packet <= pb.item.end_of_packet;
        offer = 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          // A zero gap joins two bursts into one long stretch without idling.
          burst_left = $urandom_range(0, 59);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
    in_if.valid <= offer;
  end

  // --------------------------------------------------------------------------
  // Result receiver: the stall pattern is redrawn from four modes whenever the
  // low bits of the phase counter wrap. Once, after enough traffic, it holds off
  // for a long stretch so that the block backs up into its input.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : result_receiver
    logic take;
    take = 1'b0;
    if (rst_n) begin
      stall_phase = stall_phase + 16'd1;
      if (stall_phase[5:0] == 6'd0) stall_mode = $urandom_range(0, 3);
      if (hold_left != 0) begin
        hold_left--;
      end else if (!long_hold_done && bytes_accepted >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end else begin
        case (stall_mode)
          0:       take = 1'b1;
          1:       take = $urandom_range(0, 1);
          2:       take = ($urandom_range(0, 9) != 0);
          default: take = (stall_phase[1:0] != 2'd3);
        endcase
      end
    end
    out_if.ready <= take;
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on every accepted byte and checks every accepted result
  // against the oldest expectation, field by field.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    frame_result_t want;
    bit            result_taken;
    if (rst_n) begin
      byte_taken   = in_if.valid && in_if.ready;
      result_taken = out_if.valid && out_if.ready;
      if (byte_taken) begin
        deframe_byte(in_if.data_byte, in_if.end_of_packet);
        bytes_accepted++;
      end
      if (result_taken) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: result with none expected: kind %0d i %h q %h gain %h seq %h",
                   $time, out_if.kind, out_if.i_value, out_if.q_value, out_if.gain,
                   out_if.seq_number);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_if.kind !== want.kind) begin
            $display("%0t ns: kind expected %0d actual %0d", $time, want.kind, out_if.kind);
            mismatch_count++;
          end
          if (out_if.i_value !== want.i_value) begin
            $display("%0t ns: i_value expected %h actual %h", $time, want.i_value,
                     out_if.i_value);
            mismatch_count++;
          end
          if (out_if.q_value !== want.q_value) begin
            $display("%0t ns: q_value expected %h actual %h", $time, want.q_value,
                     out_if.q_value);
            mismatch_count++;
          end
          if (out_if.gain !== want.gain) begin
            $display("%0t ns: gain expected %h actual %h", $time, want.gain, out_if.gain);
            mismatch_count++;
          end
          if (out_if.seq_number !== want.seq_number) begin
            $display("%0t ns: seq_number expected %h actual %h", $time, want.seq_number,
                     out_if.seq_number);
            mismatch_count++;
          end
        end
      end
      idle_cycles = (byte_taken || result_taken) ? 0 : idle_cycles + 1;
    end else begin
      byte_taken = 1'b0;
    end
  end

  // Watchdog: too long without any handshake on either channel.
  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t ns: no item moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int          pick;
    int          roll;
    int          n_samples;
    int          cut;
    int          packets;
    logic [15:0] seq;
    logic [15:0] count;
    logic [15:0] gen_seq;
    logic [16:0] sum;

    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.end_of_packet = 1'b0;
    out_if.ready        = 1'b0;

    // First packet after reset: any number is taken. Its single sample has
    // the extreme codes, all ones for I and all zeros for Q.
    append_header(16'h0010, 8'hFF, 16'h0001);
    packet_bytes.push_back(8'hFF);
    packet_bytes.push_back(8'hFF);
    packet_bytes.push_back(8'hFF);
    packet_bytes.push_back(8'h00);
    packet_bytes.push_back(8'h00);
    packet_bytes.push_back(8'h00);
    flush_packet(1'b0);
    // Wrong first marker byte, ending the packet at once.
    packet_bytes.push_back(8'hFF);
    flush_packet(1'b0);
    // Packet that ends after the first marker byte.
    packet_bytes.push_back(ipd_pkg::MARK_FIRST);
    flush_packet(1'b0);
    // Wrong second marker byte.
    packet_bytes.push_back(ipd_pkg::MARK_FIRST);
    packet_bytes.push_back(8'h00);
    flush_packet(1'b0);
    // Stale number behind the expectation on the same parity: dropped.
    append_header(16'h000E, 8'h01, 16'h0000);
    flush_packet(1'b0);
    // Number ahead of the expectation: a gap, still accepted. The sum passes
    // the top, so the expectation wraps. A lone trailing byte is discarded.
    append_header(16'hFFFF, 8'h5A, 16'h0002);
    packet_bytes.push_back(8'h80);
    flush_packet(1'b0);

    // Random packets, mostly well formed with random content.
    gen_seq = 16'h0000;
    packets = 0;
    while (byte_queue.size() < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // Noise: first byte is random and rarely a marker.
        packet_bytes.push_back(8'($urandom));
        repeat ($urandom_range(0, 4)) packet_bytes.push_back(8'($urandom));
      end else if (pick < 10) begin
        packet_bytes.push_back(ipd_pkg::MARK_FIRST);
        packet_bytes.push_back(8'($urandom));
        repeat ($urandom_range(0, 4)) packet_bytes.push_back(8'($urandom));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) seq = gen_seq;
        else if (roll < 72) seq = gen_seq - 16'(2 * $urandom_range(1, 4));
        else if (roll < 82) seq = 16'($urandom);
        else if (roll < 92) seq = 16'hFFFF - 16'($urandom_range(0, 3));
        else seq = gen_seq + 16'($urandom_range(1, 5));
        // Follow the number forward unless the packet was meant to be stale.
        if (roll < 60 || roll >= 72) begin
          sum     = {1'b0, seq} + 17'd2;
          gen_seq = sum[16] ? {15'd0, ~sum[0]} : sum[15:0];
        end
        roll = $urandom_range(0, 9);
        if (roll < 6) count = 16'($urandom_range(0, 3));
        else if (roll < 9) count = 16'($urandom_range(4, 8));
        else count = 16'($urandom);
        // A huge count is never met; the packet just ends early.
        n_samples = (count <= 16'd8) ? int'(count) : $urandom_range(0, 6);
        append_header(seq, 8'($urandom), count);
        repeat (6 * n_samples) packet_bytes.push_back(8'($urandom));
        roll = $urandom_range(0, 9);
        if (roll == 7) begin
          repeat ($urandom_range(1, 4)) packet_bytes.push_back(8'($urandom));
        end else if (roll == 8) begin
          repeat ($urandom_range(1, 5)) packet_bytes.push_back(8'($urandom));
        end else if (roll == 9) begin
          // Truncated packet, possibly inside the header.
          cut = $urandom_range(1, packet_bytes.size());
          while (packet_bytes.size() > cut) void'(packet_bytes.pop_back());
        end
      end
      flush_packet((packets % 25) == 24);
      packets++;
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last byte to go in, then for every result to come out,
    // then keep watching to catch anything unexpected.
    while (byte_queue.size() != 0 || in_if.valid) @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> iq_packet_deframer.f
src/ipd_pkg.sv
src/ipd_stream_if.sv
src/ipd_frame_core.sv
src/iq_packet_deframer.sv
bench/iq_packet_deframer_tb.sv
